/* hdl/pif_pkg.sv */
// Shared types and constants for the peak interval finder.
`timescale 1ns / 1ps
`default_nettype none

package pif_pkg;

    // Longest vector the index counter covers; the index saturates one below.
    localparam int MaxSamples = 4096;
    localparam int IdxW       = $clog2(MaxSamples + 1);
    localparam int SampleW    = 32;
    localparam int LevelW     = 31;
    localparam int KindW      = 2;
    localparam int CfgIdxW    = 1;

    // Result queue depth; power of two.
    localparam int QDepth     = 8;
    localparam int QPtrW      = $clog2(QDepth);
    localparam int QCntW      = $clog2(QDepth + 1);

    localparam int OutDataW   = ((2 * IdxW + 7) / 8) * 8;

    typedef logic [IdxW-1:0] t_idx;

    typedef enum logic [KindW-1:0] {
        KIND_RUN       = 2'd0,
        KIND_SENTINEL  = 2'd1,
        KIND_MALFORMED = 2'd2
    } t_kind;

    typedef enum logic [CfgIdxW-1:0] {
        REG_PEAK_LEVEL  = 1'd0,
        REG_SKIRT_LEVEL = 1'd1
    } t_reg_idx;

    typedef struct packed {
        t_kind kind;
        t_idx  run_start;
        t_idx  run_end;
        logic  final_res;
    } t_result;

endpackage

`default_nettype wire

/* hdl/peak_interval_finder.sv */
// Top level of the peak interval finder: sample register, run tracker, result queue.
`timescale 1ns / 1ps
`default_nettype none

//  channel   direction  handshake               payload
//  ---------------------------------------------------------------------------------
//  s (in)    input      i_s_tvalid / o_s_tready  tdata[31:0] sample, tlast = last
//  m (out)   output     o_m_tvalid / i_m_tready  tdata[12:0] run_start, [25:13] run_end,
//                                                tuser = kind, tlast = final_res
//  cfg       input      i_cfg_valid/o_cfg_ready  index 0 peak_level, 1 skirt_level
//
//  Latency: a word is registered on accept, scanned in the next cycle, and its
//  results land in an eight-entry queue that drives the m channel directly.
//  Throughput is one sample per cycle; the only limit is queue room, since a
//  final sample may push two results.
//  Reset (synchronous, active low) clears both levels, the run state and the queue.
//  A stall on m only backs up into the queue; s keeps flowing until it is nearly full.

module peak_interval_finder (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // stream in
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire  [pif_pkg::SampleW-1:0]         i_s_tdata,   // [31:0] sample
    input  wire                                 i_s_tlast,   // last
    // stream out
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    output logic [pif_pkg::OutDataW-1:0]        o_m_tdata,   // [12:0] run_start, [25:13] run_end
    output logic [pif_pkg::KindW-1:0]           o_m_tuser,   // [1:0] kind
    output logic                                o_m_tlast,   // final_res
    // configuration writes
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [pif_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  wire  [pif_pkg::LevelW-1:0]          i_cfg_data
);

    // ---------------------------------------------------------------- config
    logic [pif_pkg::LevelW-1:0] r_peak_level;
    logic [pif_pkg::LevelW-1:0] r_skirt_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_level  <= '0;
            r_skirt_level <= '0;
        end else if (i_cfg_valid) begin
            case (pif_pkg::t_reg_idx'(i_cfg_index))
                pif_pkg::REG_PEAK_LEVEL:  r_peak_level  <= i_cfg_data;
                pif_pkg::REG_SKIRT_LEVEL: r_skirt_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------- input stage
    logic                        r_in_valid;
    logic [pif_pkg::SampleW-1:0] r_sample;
    logic                        r_last;
    logic                        s_accept;

    assign s_accept = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= s_accept;
        end
    end

    // payload holds until the next accepted word
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_sample <= i_s_tdata;
            r_last   <= i_s_tlast;
        end
    end

    // ----------------------------------------------------------- run tracker
    logic          r_in_run, n_in_run;
    pif_pkg::t_idx r_position, n_position;
    logic          r_below_seen, n_below_seen;
    pif_pkg::t_idx r_last_below, n_last_below;
    pif_pkg::t_idx r_open_start, n_open_start;

    logic [pif_pkg::SampleW-1:0] mag;
    logic [pif_pkg::SampleW-1:0] peak_ext;
    logic [pif_pkg::SampleW-1:0] skirt_ext;
    logic                        is_peak;
    logic                        is_low;
    logic                        malformed;
    pif_pkg::t_idx               below_next;
    pif_pkg::t_idx               p_next;
    pif_pkg::t_result            res0, res1;
    logic [1:0]                  push_cnt;

    // exact magnitude: the most negative code maps to 2^31, which still fits 32 bits
    assign mag        = r_sample[pif_pkg::SampleW-1] ? (~r_sample + 1'b1) : r_sample;
    assign peak_ext   = {1'b0, r_peak_level};
    assign skirt_ext  = {1'b0, r_skirt_level};
    assign is_peak    = mag > peak_ext;
    assign is_low     = mag < skirt_ext;
    assign malformed  = r_peak_level < r_skirt_level;
    assign below_next = r_last_below + 1'b1;
    assign p_next     = r_position + 1'b1;

    always_comb begin
        n_in_run     = r_in_run;
        n_below_seen = r_below_seen;
        n_last_below = r_last_below;
        n_open_start = r_open_start;
        n_position   = r_position;
        res0         = '{kind: pif_pkg::KIND_RUN, run_start: '0, run_end: '0, final_res: 1'b0};
        res1         = res0;
        push_cnt     = 2'd0;

        if (r_in_valid) begin
            // advance the index, holding at the top
            if (r_position < pif_pkg::t_idx'(pif_pkg::MaxSamples - 1)) begin
                n_position = p_next;
            end

            if (malformed) begin
                if (r_last) begin
                    res0.kind      = pif_pkg::KIND_MALFORMED;
                    res0.final_res = 1'b1;
                    push_cnt       = 2'd1;
                end
            end else begin
                if (!r_in_run) begin
                    if (is_peak) begin
                        // open at the sample after the latest low one, else at the peak
                        n_open_start = (r_below_seen && (below_next < r_position))
                                       ? below_next : r_position;
                        n_in_run     = 1'b1;
                    end else if (is_low) begin
                        n_below_seen = 1'b1;
                        n_last_below = r_position;
                    end
                end else if (is_low) begin
                    // close the run just before this sample
                    res0.run_start = r_open_start;
                    res0.run_end   = (r_position > r_open_start) ? (r_position - 1'b1)
                                                                 : r_open_start;
                    push_cnt       = 2'd1;
                    n_in_run       = 1'b0;
                    n_below_seen   = 1'b1;
                    n_last_below   = r_position;
                end

                if (r_last) begin
                    if (n_in_run) begin
                        // run still open at the end of the vector: close it here
                        res0.run_start = n_open_start;
                        res0.run_end   = r_position;
                        res1.kind      = pif_pkg::KIND_SENTINEL;
                        res1.run_end   = p_next;
                        res1.final_res = 1'b1;
                        push_cnt       = 2'd2;
                    end else if (push_cnt == 2'd1) begin
                        res1.kind      = pif_pkg::KIND_SENTINEL;
                        res1.run_end   = p_next;
                        res1.final_res = 1'b1;
                        push_cnt       = 2'd2;
                    end else begin
                        res0.kind      = pif_pkg::KIND_SENTINEL;
                        res0.run_end   = p_next;
                        res0.final_res = 1'b1;
                        push_cnt       = 2'd1;
                    end
                end
            end

            // the final word returns the run state to its reset values
            if (r_last) begin
                n_in_run     = 1'b0;
                n_position   = '0;
                n_below_seen = 1'b0;
                n_last_below = '0;
                n_open_start = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run     <= 1'b0;
            r_position   <= '0;
            r_below_seen <= 1'b0;
            r_last_below <= '0;
            r_open_start <= '0;
        end else begin
            r_in_run     <= n_in_run;
            r_position   <= n_position;
            r_below_seen <= n_below_seen;
            r_last_below <= n_last_below;
            r_open_start <= n_open_start;
        end
    end

    // ----------------------------------------------------------- result queue
    pif_pkg::t_result                r_q [pif_pkg::QDepth];
    logic [pif_pkg::QPtrW-1:0]       r_wr_ptr, n_wr_ptr;
    logic [pif_pkg::QPtrW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [pif_pkg::QCntW-1:0]       r_count, n_count;
    logic [pif_pkg::QPtrW-1:0]       wr_ptr_1;
    logic                            m_pop;
    logic [pif_pkg::QCntW:0]         room_need;
    pif_pkg::t_result                head;

    assign wr_ptr_1 = r_wr_ptr + 1'b1;
    assign m_pop    = o_m_tvalid && i_m_tready;
    assign n_wr_ptr = r_wr_ptr + pif_pkg::QPtrW'(push_cnt);
    assign n_rd_ptr = r_rd_ptr + pif_pkg::QPtrW'(m_pop);
    assign n_count  = r_count + pif_pkg::QCntW'(push_cnt) - pif_pkg::QCntW'(m_pop);

    // accept only if the queue can absorb two results from the word in flight
    // and two from the new one, ignoring any pop this cycle
    assign room_need  = {1'b0, r_count} + ((pif_pkg::QCntW + 1)'(r_in_valid) << 1);
    assign o_s_tready = room_need <= (pif_pkg::QCntW + 1)'(pif_pkg::QDepth - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (push_cnt == 2'd2) begin
            r_q[wr_ptr_1] <= res1;
        end
    end

    assign head       = r_q[r_rd_ptr];
    assign o_m_tvalid = r_count != '0;
    assign o_m_tdata  = {{(pif_pkg::OutDataW - 2 * pif_pkg::IdxW){1'b0}},
                         head.run_end, head.run_start};
    assign o_m_tuser  = head.kind;
    assign o_m_tlast  = head.final_res;

endmodule

`default_nettype wire

/* tb/sv/tb_peak_interval_finder.sv */
// Self-checking testbench for the peak interval finder: directed table, random vectors.
`timescale 1ns / 1ps

module tb_peak_interval_finder;

    import pif_pkg::*;

    // Cycles the block may still spend on a word after its last result is out.
    localparam int DRAIN_CYCLES  = 8;
    // Quiet window at the end in which no further result may appear.
    localparam int SETTLE_CYCLES = 40;
    // Long receiver hold-off that backs the result queue up into the input.
    localparam int HOLD_CYCLES   = 300;
    // Watchdog limit; covers the slowest clean run (about 800 words, random gaps on
    // both sides, two results per word at most, drains around each level write).
    localparam int TIMEOUT_NS    = 2_000_000;

    typedef enum int {ROW_CFG, ROW_ITEM} row_op_e;
    typedef enum int {CLS_BELOW, CLS_MID, CLS_PEAK, CLS_NOISE} sample_cls_e;
    typedef enum int {VEC_PLAIN, VEC_DENSE, VEC_QUIET} vec_mode_e;

    // One row of the directed table; typed rows carry their results written out.
    typedef struct {
        row_op_e     op;
        t_reg_idx    reg_sel;
        logic [31:0] val;
        logic        fin;
        bit          typed;
        int          n_typed;
        t_result     r0;
        t_result     r1;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic [SampleW-1:0]   s_tdata;
    logic                 s_tlast;
    logic                 m_tready;
    logic                 cfg_valid;
    t_reg_idx             cfg_index;
    logic [LevelW-1:0]    cfg_data;

    wire                  o_s_tready;
    wire                  o_m_tvalid;
    wire [OutDataW-1:0]   o_m_tdata;
    wire [KindW-1:0]      o_m_tuser;
    wire                  o_m_tlast;
    wire                  o_cfg_ready;

    // Predictor copy of the levels and the run tracker.
    logic [LevelW-1:0]    peak_lvl  = '0;
    logic [LevelW-1:0]    skirt_lvl = '0;
    bit                   run_open  = 1'b0;
    bit                   below_hit = 1'b0;
    int                   next_idx  = 0;
    int                   below_idx = 0;
    int                   run_first = 0;
    t_result              scan_results[$];

    // Results still owed by the block, oldest first.
    t_result              pending_results[$];
    int                   mismatches = 0;

    // Typed expectations for the directed row now on the bus.
    bit                   typed_on = 1'b0;
    int                   typed_n  = 0;
    t_result              typed_first;
    t_result              typed_second;

    bit                   hold_go     = 1'b0;
    bit                   hold_active = 1'b0;
    bit                   rush        = 1'b0;
    int                   send_calm   = 0;
    int                   recv_calm   = 0;
    stim_row_t            directed_rows[$];

    peak_interval_finder u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic t_result outcome(t_kind k, int s, int e, bit f);
        return t_result'{k, t_idx'(s), t_idx'(e), f};
    endfunction

    function automatic void clear_runs();
        run_open  = 1'b0;
        next_idx  = 0;
        below_hit = 1'b0;
        below_idx = 0;
        run_first = 0;
    endfunction

    // Advance the run tracker by one sample; leave its results in scan_results.
    function automatic void track_runs(logic [31:0] smp, logic fin);
        logic [31:0] mag;
        int          here;
        // exact magnitude: the most negative value maps to 2^31 as unsigned
        mag  = smp[31] ? (~smp + 32'd1) : smp;
        here = next_idx;
        scan_results.delete();
        if (next_idx < MaxSamples - 1) begin
            next_idx++;
        end
        // Inverted levels: only count, report once at the end of the vector.
        if (peak_lvl < skirt_lvl) begin
            if (fin) begin
                scan_results.push_back(outcome(KIND_MALFORMED, 0, 0, 1'b1));
                clear_runs();
            end
            return;
        end
        if (!run_open) begin
            if (mag > {1'b0, peak_lvl}) begin
                // open just past the latest low sample, never above the peak
                run_first = (below_hit && below_idx + 1 < here) ? below_idx + 1 : here;
                run_open  = 1'b1;
            end else if (mag < {1'b0, skirt_lvl}) begin
                below_hit = 1'b1;
                below_idx = here;
            end
        end else if (mag < {1'b0, skirt_lvl}) begin
            scan_results.push_back(outcome(KIND_RUN, run_first,
                                           (here > run_first) ? here - 1 : run_first, 1'b0));
            run_open  = 1'b0;
            below_hit = 1'b1;
            below_idx = here;
        end
        if (fin) begin
            if (run_open) begin
                scan_results.push_back(outcome(KIND_RUN, run_first, here, 1'b0));
            end
            scan_results.push_back(outcome(KIND_SENTINEL, 0, here + 1, 1'b1));
            clear_runs();
        end
    endfunction

    function automatic void note_mismatch(string msg);
        if (mismatches < 10) begin
            $display("%s", msg);
        end
        mismatches++;
    endfunction

    // Draw a random wait, with occasional stretches of no waiting at all.
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // Build a sample of the given class against the current levels.
    function automatic logic [31:0] draw_sample(sample_cls_e cls);
        longint lo;
        longint hi;
        longint mag;
        bit     neg;
        case (cls)
            CLS_PEAK: begin
                lo = longint'(peak_lvl) + 1;
                hi = 64'h8000_0000;
            end
            CLS_BELOW: begin
                lo = 0;
                hi = longint'(skirt_lvl) - 1;
            end
            CLS_MID: begin
                lo = longint'(skirt_lvl);
                hi = longint'(peak_lvl);
            end
            default: begin
                lo = 1;
                hi = 0;
            end
        endcase
        // empty class or noise: any 32-bit pattern
        if (lo > hi) begin
            return $urandom();
        end
        if ($urandom_range(0, 7) == 0) begin
            mag = $urandom_range(0, 1) ? lo : hi;
        end else begin
            mag = lo + longint'($urandom_range(32'(hi - lo)));
        end
        neg = $urandom_range(0, 1);
        if (mag == 64'h8000_0000) begin
            neg = 1'b1;
        end
        return neg ? 32'(-mag) : 32'(mag);
    endfunction

    function automatic sample_cls_e pick_class(vec_mode_e mode, int k);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            VEC_DENSE: return k[0] ? CLS_BELOW : CLS_PEAK;
            VEC_QUIET: return (r < 3) ? CLS_PEAK : (r < 6) ? CLS_BELOW : CLS_MID;
            default:   return (r < 30) ? CLS_BELOW : (r < 65) ? CLS_MID :
                              (r < 88) ? CLS_PEAK : CLS_NOISE;
        endcase
    endfunction

    function automatic void cfg_row(t_reg_idx sel, logic [LevelW-1:0] lvl);
        stim_row_t row;
        row.op      = ROW_CFG;
        row.reg_sel = sel;
        row.val     = {1'b0, lvl};
        row.fin     = 1'b0;
        row.typed   = 1'b0;
        row.n_typed = 0;
        row.r0      = '0;
        row.r1      = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void item_row(logic [31:0] smp, logic fin, bit typed = 1'b0,
                                     int n = 0, t_result r0 = '0, t_result r1 = '0);
        stim_row_t row;
        row.op      = ROW_ITEM;
        row.reg_sel = REG_PEAK_LEVEL;
        row.val     = smp;
        row.fin     = fin;
        row.typed   = typed;
        row.n_typed = n;
        row.r0      = r0;
        row.r1      = r1;
        directed_rows.push_back(row);
    endfunction

    // Offer one word after a random gap; return at the falling edge after it is taken.
    task automatic send_word(logic [31:0] smp, logic fin);
        int gap;
        gap = rush ? 0 : pick_wait(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= fin;
        do @(posedge clk); while (!o_s_tready);
        @(negedge clk);
    endtask

    task automatic send_vector(int len, vec_mode_e mode);
        for (int k = 0; k < len; k++) begin
            send_word(draw_sample(pick_class(mode, k)), k == len - 1);
        end
    endtask

    // Write a level only once the block has gone quiet.
    task automatic write_level(t_reg_idx sel, logic [LevelW-1:0] lvl);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= lvl;
        do @(posedge clk); while (!o_cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [LevelW-1:0] pk, logic [LevelW-1:0] sk, int budget);
        int sent;
        int len;
        sent = 0;
        write_level(REG_PEAK_LEVEL, pk);
        write_level(REG_SKIRT_LEVEL, sk);
        while (sent < budget) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 20);
            send_vector(len, VEC_PLAIN);
            sent += len;
        end
    endtask

    // Scoreboard: check the result word first, then predict from the input word.
    always @(posedge clk) begin : observe
        t_result got;
        t_result want;
        if (rst_n) begin
            if (o_m_tvalid && m_tready) begin
                got = outcome(t_kind'(o_m_tuser), int'(o_m_tdata[IdxW-1:0]),
                              int'(o_m_tdata[2*IdxW-1:IdxW]), o_m_tlast);
                if (pending_results.size() == 0) begin
                    note_mismatch($sformatf(
                        "unexpected result: kind %0d start %0d end %0d fin %0b",
                        got.kind, got.run_start, got.run_end, got.final_res));
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        note_mismatch($sformatf(
                            "got %0d %0d %0d %0b, expected %0d %0d %0d %0b (kind start end fin)",
                            got.kind, got.run_start, got.run_end, got.final_res,
                            want.kind, want.run_start, want.run_end, want.final_res));
                    end
                end
            end
            if (s_tvalid && o_s_tready) begin
                track_runs(s_tdata, s_tlast);
                if (typed_on) begin
                    if (typed_n > 0) begin
                        pending_results.push_back(typed_first);
                    end
                    if (typed_n > 1) begin
                        pending_results.push_back(typed_second);
                    end
                end else begin
                    foreach (scan_results[j]) begin
                        pending_results.push_back(scan_results[j]);
                    end
                end
            end
            if (cfg_valid && o_cfg_ready) begin
                if (cfg_index == REG_PEAK_LEVEL) begin
                    peak_lvl = cfg_data;
                end else begin
                    skirt_lvl = cfg_data;
                end
            end
        end
    end

    // Result receiver: random stall per word, plus the long hold-off when asked.
    initial begin : sink
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            stall = pick_wait(recv_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            while (hold_active) begin
                m_tready <= 1'b0;
                @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!o_m_tvalid);
        end
    end

    // Hold off the receiver for a fixed stretch, counted here in clock cycles.
    initial begin : hold_off
        wait (hold_go);
        @(posedge clk);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        logic [LevelW-1:0] lv_a;
        logic [LevelW-1:0] lv_b;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_PEAK_LEVEL;
        cfg_data  = '0;

        // Levels at reset are both zero: any nonzero magnitude is a peak.
        item_row(32'h0000_0000, 1'b1, 1'b1, 1, outcome(KIND_SENTINEL, 0, 1, 1'b1));
        item_row(32'h8000_0000, 1'b0, 1'b1, 0);
        item_row(32'h7FFF_FFFF, 1'b1, 1'b1, 2, outcome(KIND_RUN, 0, 1, 1'b0),
                 outcome(KIND_SENTINEL, 0, 2, 1'b1));
        // peak below skirt: count silently, flag malformed on the final word
        cfg_row(REG_SKIRT_LEVEL, 31'h7FFF_FFFF);
        item_row(32'h1234_5678, 1'b0, 1'b1, 0);
        item_row(32'hFFFF_FFFF, 1'b1, 1'b1, 1, outcome(KIND_MALFORMED, 0, 0, 1'b1));
        // both levels at full scale: only the most negative sample is a peak
        cfg_row(REG_PEAK_LEVEL, 31'h7FFF_FFFF);
        item_row(32'h0000_0001, 1'b0);
        item_row(32'h7FFF_FFFF, 1'b0);
        item_row(32'h8000_0000, 1'b0);
        item_row(32'h8000_0001, 1'b0);
        item_row(32'h0000_0000, 1'b0);
        item_row(32'h8000_0000, 1'b1);
        // mid levels: samples exactly at each level, one run closed before the final word, one by it
        cfg_row(REG_PEAK_LEVEL, 31'h4000_0000);
        cfg_row(REG_SKIRT_LEVEL, 31'h1000_0000);
        item_row(32'h4000_0001, 1'b0);
        item_row(32'hC000_0000, 1'b0);
        item_row(32'h0FFF_FFFF, 1'b0);
        item_row(32'hF000_0000, 1'b0);
        item_row(32'hBFFF_FFFF, 1'b0);
        item_row(32'h0000_0000, 1'b1);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].op == ROW_CFG) begin
                write_level(directed_rows[i].reg_sel, directed_rows[i].val[LevelW-1:0]);
            end else begin
                typed_on     = directed_rows[i].typed;
                typed_n      = directed_rows[i].n_typed;
                typed_first  = directed_rows[i].r0;
                typed_second = directed_rows[i].r1;
                send_word(directed_rows[i].val, directed_rows[i].fin);
            end
        end
        typed_on = 1'b0;

        // Alternate peaks and lows back to back while the receiver is held off,
        // so the result queue fills and the input stalls.
        write_level(REG_PEAK_LEVEL, 31'h4000_0000);
        write_level(REG_SKIRT_LEVEL, 31'h0800_0000);
        hold_go = 1'b1;
        rush    = 1'b1;
        send_vector(64, VEC_DENSE);
        rush    = 1'b0;
        run_phase(31'h4000_0000, 31'h0800_0000, 90);

        // equal levels, full-scale peak with zero skirt, both zero
        run_phase(31'h2000_0000, 31'h2000_0000, 90);
        run_phase(31'h7FFF_FFFF, 31'h0000_0000, 90);
        run_phase(31'h0000_0000, 31'h0000_0000, 90);

        // inverted levels
        lv_a = 31'($urandom_range(0, 32'h7FFF_FFFE));
        lv_b = 31'($urandom_range(32'h7FFF_FFFF, 32'(lv_a) + 1));
        run_phase(lv_a, lv_b, 90);

        // random levels in either order, so inverted ones too
        repeat (2) begin
            lv_a = 31'($urandom());
            lv_b = 31'($urandom());
            if (lv_a >= lv_b) begin
                run_phase(lv_a, lv_b, 60);
            end else begin
                run_phase(lv_a, lv_b, 60);
            end
        end

        // small levels near zero
        lv_a = 31'($urandom_range(0, 255));
        lv_b = 31'($urandom_range(0, 32'(lv_a)));
        run_phase(lv_a, lv_b, 90);

        // Quiet vector: wide runs over long mid stretches, words back to back.
        write_level(REG_PEAK_LEVEL, 31'h3000_0000);
        write_level(REG_SKIRT_LEVEL, 31'h0100_0000);
        rush = 1'b1;
        send_vector(40, VEC_QUIET);
        rush = 1'b0;

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* peak_interval_finder.f */
hdl/pif_pkg.sv
hdl/peak_interval_finder.sv
tb/sv/tb_peak_interval_finder.sv
